@@ design/fct_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// fct_pkg
// Shared types and codes for the fault code table: command word, result
// word, stored entry and the operation, status and outcome codes.
// ----------------------------------------------------------------------------
package fct_pkg;

    localparam int FCT_DEPTH = 16;

    localparam logic [1:0] OP_REPORT = 2'd0;
    localparam logic [1:0] OP_CLEAR  = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;
    localparam logic [1:0] OP_LIST   = 2'd3;

    localparam logic [1:0] RS_PASSED    = 2'd0;
    localparam logic [1:0] RS_FAILED    = 2'd1;
    localparam logic [1:0] RS_CONFIRMED = 2'd2;

    localparam logic [1:0] ST_NONE      = 2'd0;
    localparam logic [1:0] ST_FAILED    = 2'd1;
    localparam logic [1:0] ST_CONFIRMED = 2'd2;

    localparam logic [1:0] OC_OK   = 2'd0;
    localparam logic [1:0] OC_MISS = 2'd1;
    localparam logic [1:0] OC_FULL = 2'd2;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [15:0] fault_code;
        logic [1:0]  reported_status;
    } t_cmd;

    typedef struct packed {
        logic [1:0]  outcome;
        logic [1:0]  found_status;
        logic [15:0] entry_code;
        logic [4:0]  entry_total;
        logic        final_item;
    } t_result;

    typedef struct packed {
        logic        mark;
        logic [15:0] code;
    } t_entry;

endpackage
`default_nettype wire

@@ design/fct_entry_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// fct_entry_ram
// Entry store of the fault code table: one write port and one read port,
// read data registered.
// ----------------------------------------------------------------------------
module fct_entry_ram import fct_pkg::*; #(
    parameter int DEPTH = FCT_DEPTH,
    parameter int AW    = 4
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  t_entry        i_wdata,
    input  logic [AW-1:0] i_raddr,
    output t_entry        o_rdata
);

    t_entry mem [DEPTH];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

@@ design/fault_code_table.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// fault_code_table
// Ordered table of diagnostic fault codes with failed/confirmed marks:
// report, clear, query and list operations over one entry memory.
// ----------------------------------------------------------------------------
// A command word is taken when start is high and busy is low. Each result
// word appears on o_result for exactly one cycle with o_strobe high and
// cannot be held off. The entries sit in a memory with a single read port,
// so each search or list walks the table one entry per cycle; a report
// with a reserved status and a list of an empty table are answered from
// idle without a walk. Report and query stop at a match or the last entry,
// list gives one word per cycle, and a clear (or a passed report) that
// finds its entry moves each later entry down one place, one per cycle.
// busy drops on the edge that puts out the last result word of a command.
// ----------------------------------------------------------------------------
module fault_code_table import fct_pkg::*; #(
    parameter int TABLE_DEPTH = FCT_DEPTH
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    input  t_cmd    i_cmd,
    output logic    busy,
    output logic    o_strobe,
    output t_result o_result
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [CW-1:0] FULL = CW'(TABLE_DEPTH);

    typedef enum logic [1:0] {S_IDLE, S_SEARCH, S_SHIFT, S_LIST} t_state;

    t_state        r_state, n_state;
    logic [CW-1:0] r_fill, n_fill;
    logic [CW-1:0] r_ptr, n_ptr;
    logic          r_pend, n_pend;
    logic [AW-1:0] r_ppos, n_ppos;
    t_cmd          r_cmd, n_cmd;
    logic          r_strobe, n_strobe;
    t_result       r_res, n_res;

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    t_entry        mem_wdata;
    logic [AW-1:0] mem_raddr;
    t_entry        mem_rdata;

    logic          hit;
    logic          is_remove;
    logic          is_fail;
    logic          is_conf;
    logic [1:0]    rd_status;

    function automatic t_result make_res(input logic [1:0] oc, input logic [1:0] st,
                                         input logic [15:0] code,
                                         input logic [CW-1:0] tot, input logic fin);
        t_result r;
        r.outcome      = oc;
        r.found_status = st;
        r.entry_code   = code;
        r.entry_total  = 5'(tot);
        r.final_item   = fin;
        return r;
    endfunction

    fct_entry_ram #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign hit       = r_pend && (mem_rdata.code == r_cmd.fault_code);
    assign is_remove = (r_cmd.opcode == OP_CLEAR) ||
                       ((r_cmd.opcode == OP_REPORT) && (r_cmd.reported_status == RS_PASSED));
    assign is_fail   = (r_cmd.opcode == OP_REPORT) && (r_cmd.reported_status == RS_FAILED);
    assign is_conf   = (r_cmd.opcode == OP_REPORT) && (r_cmd.reported_status == RS_CONFIRMED);
    assign rd_status = mem_rdata.mark ? ST_CONFIRMED : ST_FAILED;

    always_comb begin
        n_state   = r_state;
        n_fill    = r_fill;
        n_ptr     = r_ptr;
        n_pend    = r_pend;
        n_ppos    = r_ppos;
        n_cmd     = r_cmd;
        n_strobe  = 1'b0;
        n_res     = r_res;
        mem_we    = 1'b0;
        mem_waddr = r_ppos;
        mem_wdata = mem_rdata;
        mem_raddr = r_ptr[AW-1:0];

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_cmd  = i_cmd;
                    n_ptr  = '0;
                    n_pend = 1'b0;
                    if (i_cmd.opcode == OP_LIST) begin
                        if (r_fill == '0) begin
                            n_strobe = 1'b1;
                            n_res    = make_res(OC_MISS, ST_NONE, 16'd0, r_fill, 1'b1);
                        end else begin
                            n_state = S_LIST;
                        end
                    end else if ((i_cmd.opcode == OP_REPORT) &&
                                 (i_cmd.reported_status != RS_PASSED) &&
                                 (i_cmd.reported_status != RS_FAILED) &&
                                 (i_cmd.reported_status != RS_CONFIRMED)) begin
                        n_strobe = 1'b1;
                        n_res    = make_res(OC_OK, ST_NONE, i_cmd.fault_code, r_fill, 1'b1);
                    end else begin
                        n_state = S_SEARCH;
                    end
                end
            end
            S_SEARCH: begin
                n_pend = 1'b0;
                if (hit) begin
                    if (is_remove) begin
                        n_state = S_SHIFT;
                        n_ptr   = CW'(r_ppos) + CW'(1);
                    end else begin
                        n_state  = S_IDLE;
                        n_strobe = 1'b1;
                        if (is_fail) begin
                            mem_we    = 1'b1;
                            mem_wdata = '{mark: 1'b0, code: r_cmd.fault_code};
                            n_res     = make_res(OC_OK, ST_FAILED, r_cmd.fault_code,
                                                 r_fill, 1'b1);
                        end else if (is_conf) begin
                            mem_we    = 1'b1;
                            mem_wdata = '{mark: 1'b1, code: r_cmd.fault_code};
                            n_res     = make_res(OC_OK, ST_CONFIRMED, r_cmd.fault_code,
                                                 r_fill, 1'b1);
                        end else begin
                            n_res = make_res(OC_OK, rd_status, r_cmd.fault_code,
                                             r_fill, 1'b1);
                        end
                    end
                end else if (r_ptr >= r_fill) begin
                    n_state  = S_IDLE;
                    n_strobe = 1'b1;
                    if (is_fail) begin
                        if (r_fill < FULL) begin
                            mem_we    = 1'b1;
                            mem_waddr = r_fill[AW-1:0];
                            mem_wdata = '{mark: 1'b0, code: r_cmd.fault_code};
                            n_fill    = r_fill + CW'(1);
                            n_res     = make_res(OC_OK, ST_FAILED, r_cmd.fault_code,
                                                 r_fill + CW'(1), 1'b1);
                        end else begin
                            n_res = make_res(OC_FULL, ST_NONE, r_cmd.fault_code,
                                             r_fill, 1'b1);
                        end
                    end else begin
                        n_res = make_res(OC_MISS, ST_NONE, r_cmd.fault_code, r_fill, 1'b1);
                    end
                end else begin
                    n_pend = 1'b1;
                    n_ppos = r_ptr[AW-1:0];
                    n_ptr  = r_ptr + CW'(1);
                end
            end
            S_SHIFT: begin
                n_pend = 1'b0;
                if (r_pend) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_ppos - AW'(1);
                    mem_wdata = mem_rdata;
                end
                if (r_ptr < r_fill) begin
                    n_pend = 1'b1;
                    n_ppos = r_ptr[AW-1:0];
                    n_ptr  = r_ptr + CW'(1);
                end else begin
                    n_state  = S_IDLE;
                    n_fill   = r_fill - CW'(1);
                    n_strobe = 1'b1;
                    n_res    = make_res(OC_OK, ST_NONE, r_cmd.fault_code,
                                        r_fill - CW'(1), 1'b1);
                end
            end
            S_LIST: begin
                n_pend = 1'b0;
                if (r_pend) begin
                    n_strobe = 1'b1;
                    n_res    = make_res(OC_OK, rd_status, mem_rdata.code, r_fill,
                                        CW'(r_ppos) == (r_fill - CW'(1)));
                end
                if (r_ptr < r_fill) begin
                    n_pend = 1'b1;
                    n_ppos = r_ptr[AW-1:0];
                    n_ptr  = r_ptr + CW'(1);
                end else begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_fill   <= '0;
            r_pend   <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_fill   <= n_fill;
            r_pend   <= n_pend;
            r_strobe <= n_strobe;
        end
        r_ptr  <= n_ptr;
        r_ppos <= n_ppos;
        r_cmd  <= n_cmd;
        r_res  <= n_res;
    end

    assign busy     = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_result = r_res;

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FULL)
        else $error("fill count above table depth");

    a_done_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_strobe)
        else $error("command finished without a result word");

    a_list_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_result.final_item) |=> o_strobe)
        else $error("gap inside a list run");

    a_accept_reply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy || o_strobe))
        else $error("accepted command neither working nor answered");
`endif

endmodule
`default_nettype wire

@@ tb/fault_code_table_tb.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// fault_code_table_tb
// Self-checking bench for the fault code table. A model of the table in
// the bench predicts every result word for each accepted command word.
// Directed words cover an empty table, filling to full, status marks and
// removal. Random traffic then runs mostly over a small pool of codes with
// sender idle bursts, a pause until all results are back, and a final
// stretch with no idling. Each strobed word is checked field by field
// against the oldest prediction.
// ----------------------------------------------------------------------------
module fault_code_table_tb import fct_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          CMD_W         = $bits(t_cmd);
    localparam int          CYCLE_LIMIT   = 200000;
    localparam int          SETTLE_CYCLES = 2 * FCT_DEPTH + 16;
    localparam int          POOL_SIZE     = 24;
    localparam logic [1:0]  RS_RESERVED   = 2'd3;

    logic    i_clk;
    logic    i_rst_n;
    logic    start;
    t_cmd    i_cmd;
    logic    busy;
    logic    o_strobe;
    t_result o_result;

    logic [15:0] tbl_code [FCT_DEPTH];
    logic        tbl_conf [FCT_DEPTH];
    int          tbl_fill;

    t_result     expected_words [$];
    logic [15:0] code_pool [POOL_SIZE];
    int          mismatch_count;
    int          cycle_count;
    bit          gaps_on;

    fault_code_table dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_cmd    (i_cmd),
        .busy     (busy),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("fault_code_table_tb: FAIL");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatch_count++;
        $display("mismatch %s: got %0h expected %0h at cycle %0d",
                 what, got, want, cycle_count);
    endtask

    function automatic t_cmd make_cmd(input logic [1:0] op, input logic [15:0] code,
                                      input logic [1:0] rs);
        return {op, code, rs};
    endfunction

    function automatic void queue_word(input logic [1:0] outcome, input logic [1:0] st,
                                       input logic [15:0] code, input logic last);
        t_result w;
        w.outcome      = outcome;
        w.found_status = st;
        w.entry_code   = code;
        w.entry_total  = 5'(tbl_fill);
        w.final_item   = last;
        expected_words.push_back(w);
    endfunction

    function automatic void apply_to_table(input t_cmd c);
        int pos;
        pos = -1;
        for (int i = 0; i < tbl_fill; i++)
            if (pos < 0 && tbl_code[i] == c.fault_code) pos = i;
        if (c.opcode == OP_LIST) begin
            if (tbl_fill == 0) begin
                queue_word(OC_MISS, ST_NONE, 16'h0000, 1'b1);
            end else begin
                for (int i = 0; i < tbl_fill; i++)
                    queue_word(OC_OK, tbl_conf[i] ? ST_CONFIRMED : ST_FAILED,
                               tbl_code[i], i == tbl_fill - 1);
            end
        end else if (c.opcode == OP_QUERY) begin
            if (pos >= 0)
                queue_word(OC_OK, tbl_conf[pos] ? ST_CONFIRMED : ST_FAILED,
                           c.fault_code, 1'b1);
            else
                queue_word(OC_MISS, ST_NONE, c.fault_code, 1'b1);
        end else if (c.opcode == OP_CLEAR || c.reported_status == RS_PASSED) begin
            if (pos >= 0) begin
                for (int j = pos; j < tbl_fill - 1; j++) begin
                    tbl_code[j] = tbl_code[j + 1];
                    tbl_conf[j] = tbl_conf[j + 1];
                end
                tbl_fill--;
                queue_word(OC_OK, ST_NONE, c.fault_code, 1'b1);
            end else begin
                queue_word(OC_MISS, ST_NONE, c.fault_code, 1'b1);
            end
        end else if (c.reported_status == RS_FAILED) begin
            if (pos >= 0) begin
                tbl_conf[pos] = 1'b0;
                queue_word(OC_OK, ST_FAILED, c.fault_code, 1'b1);
            end else if (tbl_fill < FCT_DEPTH) begin
                tbl_code[tbl_fill] = c.fault_code;
                tbl_conf[tbl_fill] = 1'b0;
                tbl_fill++;
                queue_word(OC_OK, ST_FAILED, c.fault_code, 1'b1);
            end else begin
                queue_word(OC_FULL, ST_NONE, c.fault_code, 1'b1);
            end
        end else if (c.reported_status == RS_CONFIRMED) begin
            if (pos >= 0) begin
                tbl_conf[pos] = 1'b1;
                queue_word(OC_OK, ST_CONFIRMED, c.fault_code, 1'b1);
            end else begin
                queue_word(OC_MISS, ST_NONE, c.fault_code, 1'b1);
            end
        end else begin
            queue_word(OC_OK, ST_NONE, c.fault_code, 1'b1);
        end
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_strobe) begin
            if (expected_words.size() == 0) begin
                report_mismatch("unexpected word", int'(o_result), 0);
            end else begin
                want = expected_words.pop_front();
                if (o_result.outcome !== want.outcome)
                    report_mismatch("outcome", int'(o_result.outcome),
                                    int'(want.outcome));
                if (o_result.found_status !== want.found_status)
                    report_mismatch("found_status", int'(o_result.found_status),
                                    int'(want.found_status));
                if (o_result.entry_code !== want.entry_code)
                    report_mismatch("entry_code", int'(o_result.entry_code),
                                    int'(want.entry_code));
                if (o_result.entry_total !== want.entry_total)
                    report_mismatch("entry_total", int'(o_result.entry_total),
                                    int'(want.entry_total));
                if (o_result.final_item !== want.final_item)
                    report_mismatch("final_item", int'(o_result.final_item),
                                    int'(want.final_item));
            end
        end
    end

    task automatic send_word(input t_cmd c);
        int gap;
        gap = 0;
        if (gaps_on && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 16);
        repeat (gap) begin
            @(negedge i_clk);
            start <= 1'b0;
            i_cmd <= t_cmd'(CMD_W'($urandom));
        end
        @(negedge i_clk);
        start <= 1'b1;
        i_cmd <= c;
        do @(posedge i_clk); while (busy);
        apply_to_table(c);
    endtask

    function automatic t_cmd random_word(input int add_pct);
        int          r;
        logic [15:0] code;
        code = ($urandom_range(0, 99) < 85) ? code_pool[$urandom_range(0, POOL_SIZE - 1)]
                                            : 16'($urandom);
        if ($urandom_range(0, 99) < add_pct) return make_cmd(OP_REPORT, code, RS_FAILED);
        r = $urandom_range(0, 99);
        if (r < 15) return make_cmd(OP_REPORT, code, RS_CONFIRMED);
        if (r < 35) return make_cmd(OP_REPORT, code, RS_PASSED);
        if (r < 50) return make_cmd(OP_CLEAR, code, 2'($urandom));
        if (r < 75) return make_cmd(OP_QUERY, code, 2'($urandom));
        if (r < 90) return make_cmd(OP_LIST, 16'($urandom), 2'($urandom));
        if (r < 95) return make_cmd(OP_REPORT, code, RS_RESERVED);
        return t_cmd'(CMD_W'($urandom));
    endfunction

    task automatic send_random(input int count, input int add_pct);
        repeat (count) send_word(random_word(add_pct));
    endtask

    task automatic test_empty_table();
        send_word(make_cmd(OP_LIST, 16'hFFFF, RS_RESERVED));
        send_word(make_cmd(OP_QUERY, 16'h0000, RS_PASSED));
        send_word(make_cmd(OP_REPORT, 16'hFFFF, RS_CONFIRMED));
    endtask

    task automatic test_fill_to_full();
        for (int k = 0; k < FCT_DEPTH; k++)
            send_word(make_cmd(OP_REPORT, (k == 1) ? 16'hFFFF : 16'(k * 16'h0F0F),
                               RS_FAILED));
        send_word(make_cmd(OP_REPORT, 16'h1234, RS_FAILED));
    endtask

    task automatic test_status_marks();
        send_word(make_cmd(OP_REPORT, 16'hFFFF, RS_CONFIRMED));
        send_word(make_cmd(OP_QUERY, 16'hFFFF, RS_FAILED));
        send_word(make_cmd(OP_REPORT, 16'hFFFF, RS_FAILED));
        send_word(make_cmd(OP_REPORT, 16'h1E1E, RS_RESERVED));
    endtask

    task automatic test_removal();
        send_word(make_cmd(OP_REPORT, 16'h0000, RS_PASSED));
        send_word(make_cmd(OP_CLEAR, 16'h7878, RS_CONFIRMED));
        send_word(make_cmd(OP_LIST, 16'h0000, RS_PASSED));
    endtask

    task automatic test_random_fill();
        foreach (code_pool[i]) code_pool[i] = 16'($urandom);
        code_pool[0] = 16'h0000;
        code_pool[1] = 16'hFFFF;
        send_random(70, 70);
    endtask

    task automatic test_random_drain();
        send_random(70, 10);
    endtask

    task automatic test_random_mixed();
        send_random(60, 35);
    endtask

    task automatic test_quiet_pause();
        send_word(make_cmd(OP_LIST, 16'h0000, RS_PASSED));
        @(negedge i_clk);
        start <= 1'b0;
        while (expected_words.size() != 0) @(posedge i_clk);
        send_word(random_word(35));
    endtask

    task automatic test_random_steady();
        send_random(50, 40);
    endtask

    initial begin
        i_rst_n        = 1'b0;
        start          = 1'b0;
        i_cmd          = '0;
        tbl_fill       = 0;
        mismatch_count = 0;
        cycle_count    = 0;
        gaps_on        = 1'b1;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_table();
        test_fill_to_full();
        test_status_marks();
        test_removal();
        test_random_fill();
        test_random_drain();
        test_random_mixed();
        test_quiet_pause();
        gaps_on = 1'b0;
        test_random_steady();

        @(negedge i_clk);
        start <= 1'b0;
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("fault_code_table_tb: PASS");
        end else begin
            $display("fault_code_table_tb: FAIL");
        end
        $finish;
    end

endmodule
`default_nettype wire

@@ sim.f @@
design/fct_pkg.sv
design/fct_entry_ram.sv
design/fault_code_table.sv
tb/fault_code_table_tb.sv
